// ===== rtl/core/sfr_pkg.sv =====
`timescale 1ns / 1ps

package sfr_pkg;

	// Defaults for the top-level parameters.
	localparam int MAX_PATTERN_DEF = 8;
	localparam int LENGTH_BITS_DEF = 16;

	// Fixed widths of the register and stream fields.
	localparam int BYTE_W      = 8;
	localparam int WORD_W      = 64;
	localparam int LEN_W       = 4;
	localparam int CAP_W       = 16;
	localparam int OUT_LEN_W   = 16;
	localparam int CFG_IDX_W   = 3;
	localparam int MAX_REPL    = 8;

	// One accepted byte produces at most this many result bytes.
	localparam int MAX_RESULTS = 8;
	localparam int CNT_W       = 4;
	localparam int IDX_W       = 3;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN     = 3'd0,
		REG_PATTERN_LEN = 3'd1,
		REG_REPLACEMENT = 3'd2,
		REG_REPL_LEN    = 3'd3,
		REG_CAPACITY    = 3'd4
	} reg_idx_t;

	// Configuration register file contents.
	typedef struct packed {
		logic [WORD_W-1:0] pattern;
		logic [LEN_W-1:0]  pattern_len;
		logic [WORD_W-1:0] replacement;
		logic [LEN_W-1:0]  replacement_len;
		logic [CAP_W-1:0]  capacity;
	} cfg_t;

	// The result bytes caused by one input byte, with the end-of-string summary.
	typedef struct packed {
		logic [MAX_RESULTS-1:0][BYTE_W-1:0] data;
		logic [CNT_W-1:0]                   cnt;
		logic                               last;
		logic                               found;
		logic                               ovf;
		logic [OUT_LEN_W-1:0]               length;
	} burst_t;

	// Hand-over from the step logic to the result queue.
	typedef struct packed {
		logic   push;
		burst_t burst;
	} step_t;

endpackage

// ===== rtl/core/sfr_in_if.sv =====
`timescale 1ns / 1ps

interface sfr_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

// ===== rtl/core/sfr_out_if.sv =====
`timescale 1ns / 1ps

interface sfr_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	logic        out_last;
	logic        any_found;
	logic        overflowed;
	logic [15:0] out_length;

	modport source (output valid, output out_byte, output out_last, output any_found,
		output overflowed, output out_length, input ready);
	modport sink (input valid, input out_byte, input out_last, input any_found,
		input overflowed, input out_length, output ready);
endinterface

// ===== rtl/core/sfr_step.sv =====
`timescale 1ns / 1ps

module sfr_step #(
	parameter int MAX_PATTERN = sfr_pkg::MAX_PATTERN_DEF,
	parameter int LENGTH_BITS = sfr_pkg::LENGTH_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  sfr_pkg::cfg_t cfg,
	input  logic          acc,
	input  logic [7:0]    in_byte,
	input  logic          in_last,
	output sfr_pkg::step_t step
);
	import sfr_pkg::*;

	localparam int WCW = $clog2(MAX_PATTERN + 1);
	localparam int ECW = LENGTH_BITS + 1;
	localparam logic [ECW:0]   SAT   = (ECW + 1)'(1) << LENGTH_BITS;
	localparam logic [ECW-1:0] LMASK = {1'b0, {LENGTH_BITS{1'b1}}};

	// Window of undecided bytes and per-string counters.
	logic [BYTE_W-1:0] win_q [MAX_PATTERN];
	logic [WCW-1:0]    wcnt_q;
	logic [ECW-1:0]    ecnt_q;
	logic              seen_q;

	logic [LEN_W-1:0]  pl;
	logic [LEN_W-1:0]  rl;
	logic [LEN_W-1:0]  wcnt4;
	logic [LEN_W-1:0]  cnt2;
	logic [BYTE_W-1:0] w2 [MAX_PATTERN];
	logic [BYTE_W-1:0] rem [MAX_PATTERN];
	logic              decide;
	logic              hit;
	logic [LEN_W-1:0]  sh;
	logic [LEN_W-1:0]  remcnt;
	logic [LEN_W-1:0]  ndec;
	logic [LEN_W:0]    total;
	logic [CNT_W-1:0]  nres;
	logic [MAX_RESULTS-1:0][BYTE_W-1:0] bt;
	logic [ECW:0]      ec_sum;
	logic [ECW-1:0]    ec_new;
	logic [ECW-1:0]    cap_m;
	logic              ovf;
	logic              seen_new;

	// Clamp the length registers into their legal ranges.
	always_comb begin
		if (cfg.pattern_len == '0) begin
			pl = LEN_W'(1);
		end else if (int'(cfg.pattern_len) > MAX_PATTERN) begin
			pl = LEN_W'(MAX_PATTERN);
		end else begin
			pl = cfg.pattern_len;
		end
		if (cfg.replacement_len == '0) begin
			rl = LEN_W'(1);
		end else if (int'(cfg.replacement_len) > MAX_REPL) begin
			rl = LEN_W'(MAX_REPL);
		end else begin
			rl = cfg.replacement_len;
		end
	end

	// Append the new byte, compare against the pattern and shift out what was decided.
	always_comb begin
		wcnt4 = LEN_W'(wcnt_q);
		cnt2  = (int'(wcnt4) < MAX_PATTERN) ? wcnt4 + LEN_W'(1) : wcnt4;
		for (int i = 0; i < MAX_PATTERN; i++) begin
			w2[i] = win_q[i];
			if (i == int'(wcnt4)) begin
				w2[i] = in_byte;
			end
		end
		hit = 1'b1;
		for (int i = 0; i < MAX_PATTERN; i++) begin
			if (i < int'(pl) && w2[i] != cfg.pattern[8*i +: 8]) begin
				hit = 1'b0;
			end
		end
		decide = cnt2 >= pl;
		sh     = decide ? (hit ? pl : LEN_W'(1)) : '0;
		ndec   = decide ? (hit ? rl : LEN_W'(1)) : '0;
		remcnt = cnt2 - sh;
		for (int i = 0; i < MAX_PATTERN; i++) begin
			rem[i] = w2[i];
			for (int j = 0; j < MAX_PATTERN; j++) begin
				if (j == i + int'(sh)) begin
					rem[i] = w2[j];
				end
			end
		end
	end

	// Assemble the result bytes: the decision first, then the flush on the last byte.
	always_comb begin
		for (int j = 0; j < MAX_RESULTS; j++) begin
			bt[j] = '0;
			if (decide && hit && j < int'(rl)) begin
				bt[j] = cfg.replacement[8*j +: 8];
			end else if (decide && !hit && j == 0) begin
				bt[j] = w2[0];
			end
			for (int k = 0; k < MAX_PATTERN; k++) begin
				if (in_last && k < int'(remcnt) && j == int'(ndec) + k) begin
					bt[j] = rem[k];
				end
			end
		end
		total = (LEN_W + 1)'(ndec) + (in_last ? (LEN_W + 1)'(remcnt) : '0);
		nres  = (int'(total) > MAX_RESULTS) ? CNT_W'(MAX_RESULTS) : CNT_W'(total);
	end

	// Emitted length with saturation, and the overflow test against capacity.
	always_comb begin
		ec_sum   = (ECW + 1)'(ecnt_q) + (ECW + 1)'(nres);
		ec_new   = (ec_sum > SAT) ? SAT[ECW-1:0] : ec_sum[ECW-1:0];
		cap_m    = ECW'(cfg.capacity) & LMASK;
		ovf      = ec_new > cap_m;
		seen_new = seen_q | (decide & hit);
	end

	// Burst handed to the result queue.
	always_comb begin
		step.push         = acc && (nres != '0);
		step.burst.data   = bt;
		step.burst.cnt    = nres;
		step.burst.last   = in_last;
		step.burst.found  = seen_new;
		step.burst.ovf    = ovf;
		step.burst.length = ovf ? '0 : OUT_LEN_W'(ec_new & LMASK);
	end

	// Stream state; it returns to reset after the last byte of a string.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wcnt_q <= '0;
			ecnt_q <= '0;
			seen_q <= 1'b0;
		end else if (acc) begin
			wcnt_q <= in_last ? '0 : WCW'(remcnt);
			ecnt_q <= in_last ? '0 : ec_new;
			seen_q <= in_last ? 1'b0 : seen_new;
		end
	end

	// Window bytes carry no reset; entries beyond the count are never read.
	always_ff @(posedge clk) begin
		if (acc) begin
			for (int i = 0; i < MAX_PATTERN; i++) begin
				win_q[i] <= rem[i];
			end
		end
	end

	// The window always leaves room for the next byte.
	a_win_room: assert property (@(posedge clk) disable iff (!arst_n)
		int'(wcnt_q) < MAX_PATTERN)
		else $error("window count reached its depth");

	// A string end clears the per-string state.
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		acc && in_last |=> wcnt_q == '0 && ecnt_q == '0 && !seen_q)
		else $error("stream state not cleared after the last byte");

	// The last byte of a string always yields at least one result byte.
	a_end_pushes: assert property (@(posedge clk) disable iff (!arst_n)
		acc && in_last |-> step.push)
		else $error("string end produced no result");

endmodule

// ===== rtl/core/sfr_burst_q.sv =====
`timescale 1ns / 1ps

module sfr_burst_q (
	input  logic           clk,
	input  logic           arst_n,
	input  sfr_pkg::step_t step,
	output logic           ready,
	sfr_out_if.source      edited
);
	import sfr_pkg::*;

	// Two burst slots, emptied one byte per transaction.
	burst_t           slot_q [2];
	logic [1:0]       cnt_q;
	logic             head_q;
	logic             tail_q;
	logic [IDX_W-1:0] idx_q;

	burst_t head;
	logic   at_end;
	logic   fire;
	logic   pop;

	// Present the current byte of the oldest burst.
	always_comb begin
		head   = slot_q[head_q];
		at_end = idx_q == IDX_W'(head.cnt - CNT_W'(1));

		edited.valid      = cnt_q != 2'd0;
		fire              = edited.valid && edited.ready;
		pop               = fire && at_end;
		edited.out_byte   = head.data[idx_q];
		edited.out_last   = head.last && at_end;
		edited.any_found  = head.last && at_end && head.found;
		edited.overflowed = head.last && at_end && head.ovf;
		edited.out_length = (head.last && at_end) ? head.length : '0;
		ready             = cnt_q != 2'd2;
	end

	// Occupancy, pointers and byte index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			head_q <= 1'b0;
			tail_q <= 1'b0;
			idx_q  <= '0;
		end else begin
			cnt_q <= cnt_q + {1'b0, step.push} - {1'b0, pop};
			if (step.push) begin
				tail_q <= ~tail_q;
			end
			if (pop) begin
				head_q <= ~head_q;
				idx_q  <= '0;
			end else if (fire) begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	// Slot payload.
	always_ff @(posedge clk) begin
		if (step.push) begin
			slot_q[tail_q] <= step.burst;
		end
	end

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		step.push |-> cnt_q != 2'd2)
		else $error("burst pushed into a full queue");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("queue occupancy out of range");

	a_idx_in_burst: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd0 |-> CNT_W'(idx_q) < head.cnt)
		else $error("byte index beyond the burst length");

endmodule

// ===== rtl/core/stream_find_replace.sv =====
`timescale 1ns / 1ps

// Channel   Role      Payload
// text      sink      in_byte[7:0], in_last
// edited    source    out_byte[7:0], out_last, any_found, overflowed, out_length[15:0]
// cfg_*     write     cfg_we, cfg_index[2:0], cfg_data[63:0]
//
// One input byte is accepted per cycle while a slot is free; its result bytes enter a
// two-slot burst queue. The edited channel moves one byte per cycle while it is ready;
// a match yields replacement_len bytes; a last byte yields up to eight with the flush.
// text.ready is low only while both burst slots hold bytes not yet taken.
// Reset clears the window count, counters and queue; no clearing pass is needed.
module stream_find_replace #(
	parameter int MAX_PATTERN = sfr_pkg::MAX_PATTERN_DEF,
	parameter int LENGTH_BITS = sfr_pkg::LENGTH_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [sfr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sfr_pkg::WORD_W-1:0]    cfg_data,
	sfr_in_if.sink                        text,
	sfr_out_if.source                     edited
);
	import sfr_pkg::*;

	cfg_t  cfg_q;
	step_t step;
	logic  acc;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pattern         <= '0;
			cfg_q.pattern_len     <= LEN_W'(1);
			cfg_q.replacement     <= '0;
			cfg_q.replacement_len <= LEN_W'(1);
			cfg_q.capacity        <= '1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PATTERN: begin
					cfg_q.pattern <= cfg_data;
				end
				REG_PATTERN_LEN: begin
					cfg_q.pattern_len <= cfg_data[LEN_W-1:0];
				end
				REG_REPLACEMENT: begin
					cfg_q.replacement <= cfg_data;
				end
				REG_REPL_LEN: begin
					cfg_q.replacement_len <= cfg_data[LEN_W-1:0];
				end
				REG_CAPACITY: begin
					cfg_q.capacity <= cfg_data[CAP_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// An input transaction completes when text.valid is high and the queue has a free slot.
	assign acc = text.valid && text.ready;

	sfr_step #(
		.MAX_PATTERN(MAX_PATTERN),
		.LENGTH_BITS(LENGTH_BITS)
	) u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.acc    (acc),
		.in_byte(text.in_byte),
		.in_last(text.in_last),
		.step   (step)
	);

	sfr_burst_q u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (step),
		.ready (text.ready),
		.edited(edited)
	);

endmodule

// ===== tb/sfr_edit_checker.sv =====
`timescale 1ns / 1ps

module sfr_edit_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [sfr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sfr_pkg::WORD_W-1:0]    cfg_data,
	sfr_in_if                             text,
	sfr_out_if                            edited,
	output int                            errors,
	output int                            pending
);
	import sfr_pkg::*;

	localparam int WIN_DEPTH = MAX_PATTERN_DEF;
	localparam logic [LENGTH_BITS_DEF:0] COUNT_SAT = 1 << LENGTH_BITS_DEF;
	localparam int REPORT_LIMIT = 32;

	typedef struct packed {
		logic [BYTE_W-1:0]    data;
		logic                 last;
		logic                 found;
		logic                 ovf;
		logic [OUT_LEN_W-1:0] length;
	} edit_t;

	// Shadow copy of the register file.
	logic [WORD_W-1:0] pattern_r;
	logic [LEN_W-1:0]  pattern_len_r;
	logic [WORD_W-1:0] replacement_r;
	logic [LEN_W-1:0]  replacement_len_r;
	logic [CAP_W-1:0]  capacity_r;

	// Per-string state of the edit.
	logic [BYTE_W-1:0]          window [WIN_DEPTH];
	int                         window_cnt;
	logic [LENGTH_BITS_DEF:0]   emitted;
	logic                       match_seen;

	// Bytes produced by the transaction being predicted.
	logic [BYTE_W-1:0] step_bytes [MAX_RESULTS];
	int                step_cnt;

	edit_t expected_edits [$];
	edit_t want;

	// Length registers outside 1..hi are pulled back into range.
	function automatic int fit_len(input logic [LEN_W-1:0] v, input int hi);
		if (v == '0)
			return 1;
		return (int'(v) > hi) ? hi : int'(v);
	endfunction

	// A byte beyond the per-transaction limit is dropped and not counted.
	task automatic emit_byte(input logic [BYTE_W-1:0] v);
		if (step_cnt < MAX_RESULTS) begin
			step_bytes[step_cnt] = v;
			step_cnt++;
			if (emitted < COUNT_SAT)
				emitted++;
		end
	endtask

	task automatic drop_window(input int n);
		if (n >= window_cnt) begin
			window_cnt = 0;
		end else begin
			for (int k = 0; k + n < window_cnt; k++)
				window[k] = window[k + n];
			window_cnt -= n;
		end
	endtask

	// Works out the edited bytes caused by one input byte and queues them.
	task automatic predict_edit(input logic [BYTE_W-1:0] b, input logic final_byte);
		int    pl;
		int    rl;
		logic  hit;
		logic  ovf;
		edit_t e;
		pl = fit_len(pattern_len_r, WIN_DEPTH);
		rl = fit_len(replacement_len_r, MAX_REPL);
		step_cnt = 0;
		ovf = 1'b0;
		if (window_cnt < WIN_DEPTH) begin
			window[window_cnt] = b;
			window_cnt++;
		end
		// At most one decision per byte: a full match, or the oldest byte goes out.
		if (window_cnt >= pl) begin
			hit = 1'b1;
			for (int k = 0; k < pl; k++)
				if (window[k] != pattern_r[8*k +: 8])
					hit = 1'b0;
			if (hit) begin
				match_seen = 1'b1;
				for (int k = 0; k < rl; k++)
					emit_byte(replacement_r[8*k +: 8]);
				drop_window(pl);
			end else begin
				emit_byte(window[0]);
				drop_window(1);
			end
		end
		// The final byte flushes the window and settles the summary.
		if (final_byte) begin
			for (int k = 0; k < window_cnt; k++)
				emit_byte(window[k]);
			window_cnt = 0;
			ovf = emitted > {1'b0, capacity_r};
		end
		for (int k = 0; k < step_cnt; k++) begin
			e = '0;
			e.data = step_bytes[k];
			if (final_byte && k == step_cnt - 1) begin
				e.last = 1'b1;
				e.found = match_seen;
				e.ovf = ovf;
				e.length = ovf ? '0 : emitted[OUT_LEN_W-1:0];
			end
			expected_edits.push_back(e);
		end
		if (final_byte) begin
			emitted = '0;
			match_seen = 1'b0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_r = '0;
			pattern_len_r = 4'd1;
			replacement_r = '0;
			replacement_len_r = 4'd1;
			capacity_r = 16'hFFFF;
			window_cnt = 0;
			emitted = '0;
			match_seen = 1'b0;
			expected_edits.delete();
			errors = 0;
			pending = 0;
		end else begin
			// An input transaction sees the registers as they were before this edge.
			if (text.valid && text.ready)
				predict_edit(text.in_byte, text.in_last);

			if (cfg_we) begin
				case (cfg_index)
					REG_PATTERN:     pattern_r = cfg_data;
					REG_PATTERN_LEN: pattern_len_r = cfg_data[LEN_W-1:0];
					REG_REPLACEMENT: replacement_r = cfg_data;
					REG_REPL_LEN:    replacement_len_r = cfg_data[LEN_W-1:0];
					REG_CAPACITY:    capacity_r = cfg_data[CAP_W-1:0];
					default: ;
				endcase
			end

			// Each output transaction is held against the oldest expectation.
			if (edited.valid && edited.ready) begin
				if (expected_edits.size() == 0) begin
					errors++;
					if (errors <= REPORT_LIMIT)
						$display("%0t: unexpected edited byte %02h last %0b", $time,
							edited.out_byte, edited.out_last);
				end else begin
					want = expected_edits.pop_front();
					if (want.data !== edited.out_byte || want.last !== edited.out_last ||
						want.found !== edited.any_found ||
						want.ovf !== edited.overflowed ||
						want.length !== edited.out_length) begin
						errors++;
						if (errors <= REPORT_LIMIT)
							$display({"%0t: expected byte %02h last %0b found %0b ovf %0b ",
								"len %0d, got byte %02h last %0b found %0b ovf %0b len %0d"},
								$time, want.data, want.last, want.found, want.ovf,
								want.length, edited.out_byte, edited.out_last,
								edited.any_found, edited.overflowed, edited.out_length);
					end
				end
			end
			pending = expected_edits.size();
		end
	end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import sfr_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 20;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_BYTES = 36;
	localparam int LONG_BYTES = 24;

	typedef enum int {RX_FREE, RX_MOSTLY, RX_EVERY_THIRD, RX_COIN} rx_mode_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [WORD_W-1:0]    cfg_data;

	sfr_in_if  text_ch ();
	sfr_out_if edited_ch ();

	int fail_count;
	int pending_count;
	int cycles = 0;
	int burst_left;
	rx_mode_t rx_mode;
	int rx_left;
	int rx_tick;

	// Stimulus working variables.
	logic [7:0]  text_q [$];
	logic [63:0] pat;
	logic [63:0] repl;
	logic [3:0]  plen;
	logic [3:0]  rlen;
	logic [15:0] cap;
	logic [7:0]  alpha [3];
	int          plen_eff;
	int          sent;
	int          target;
	int          cut;

	stream_find_replace dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.text      (text_ch),
		.edited    (edited_ch)
	);

	sfr_edit_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.text      (text_ch),
		.edited    (edited_ch),
		.errors    (fail_count),
		.pending   (pending_count)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	// Receiver: switches between free flow and several stall patterns.
	initial begin
		edited_ch.ready <= 1'b0;
		rx_left = 0;
		rx_tick = 0;
		forever begin
			@(posedge clk);
			if (rx_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				rx_left = $urandom_range(20, 300);
			end
			rx_left--;
			rx_tick++;
			case (rx_mode)
				RX_FREE:        edited_ch.ready <= 1'b1;
				RX_MOSTLY:      edited_ch.ready <= ($urandom_range(0, 3) != 0);
				RX_EVERY_THIRD: edited_ch.ready <= (rx_tick % 3 == 0);
				default:        edited_ch.ready <= 1'($urandom_range(0, 1));
			endcase
		end
	end

	// Sends one byte, in bursts of random length with random gaps in between.
	task automatic put_text(input logic [7:0] b, input logic is_last);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				text_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		text_ch.valid <= 1'b1;
		text_ch.in_byte <= b;
		text_ch.in_last <= is_last;
		do @(negedge clk); while (!text_ch.ready);
		@(posedge clk);
		burst_left--;
	endtask

	task automatic send_text();
		for (int k = 0; k < text_q.size(); k++)
			put_text(text_q[k], k == text_q.size() - 1);
	endtask

	// Holds the sender until every expected byte is out and the block is quiet.
	task automatic settle();
		text_ch.valid <= 1'b0;
		burst_left = 0;
		do @(negedge clk); while (pending_count != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Leaves the write enable high; the caller lowers it after the last write.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
	endtask

	task automatic load_regs(input logic [63:0] p, input logic [63:0] pl,
		input logic [63:0] r, input logic [63:0] rl, input logic [63:0] c);
		write_reg(REG_PATTERN, p);
		write_reg(REG_PATTERN_LEN, pl);
		write_reg(REG_REPLACEMENT, r);
		write_reg(REG_REPL_LEN, rl);
		write_reg(REG_CAPACITY, c);
		cfg_we <= 1'b0;
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		text_ch.valid <= 1'b0;
		text_ch.in_byte <= '0;
		text_ch.in_last <= 1'b0;
		burst_left = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A write to an unused index must leave the reset settings alone.
		write_reg(REG_UNMAPPED, 64'hFFFF_FFFF_FFFF_FFFF);
		cfg_we <= 1'b0;
		put_text(8'h00, 1'b0);
		put_text(8'hFF, 1'b1);

		// Zero and oversized lengths, with a capacity of zero forcing overflow.
		settle();
		load_regs(64'h0000_0000_0000_0201, 64'd0, 64'hFFEE_DDCC_BBAA_9988, 64'd15, 64'd0);
		put_text(8'h01, 1'b0);
		put_text(8'h02, 1'b0);
		put_text(8'h7F, 1'b1);
		put_text(8'h01, 1'b1);

		// Full-length pattern matched on the final byte; length equals capacity.
		settle();
		load_regs(64'h8877_6655_4433_2211, 64'd8, 64'h0000_0000_0000_00A5, 64'd1, 64'd1);
		for (int k = 0; k < 8; k++)
			put_text(8'(8'h11 * (k + 1)), k == 7);

		// Pattern length lowered with seven bytes held: the final flush overruns.
		settle();
		load_regs(64'h0706_0504_0302_0110, 64'd8, 64'h0123_4567_89AB_CDEF, 64'd8,
			64'd65535);
		put_text(8'h10, 1'b0);
		for (int k = 1; k < 7; k++)
			put_text(8'(k), 1'b0);
		settle();
		write_reg(REG_PATTERN_LEN, 64'd1);
		cfg_we <= 1'b0;
		put_text(8'h99, 1'b1);

		// A string of back-to-back matches, each replaced by eight bytes.
		settle();
		load_regs(64'h5A, 64'd1, 64'hFEDC_BA98_7654_3210, 64'd8, 64'd65535);
		for (int k = 0; k < LONG_BYTES; k++)
			put_text(8'h5A, k == LONG_BYTES - 1);

		// Random phases: strings built mostly from pattern copies and near misses.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			for (int k = 0; k < 3; k++)
				alpha[k] = (ph == 7) ? 8'hFF : 8'($urandom);
			for (int k = 0; k < 8; k++)
				pat[8*k +: 8] = alpha[$urandom_range(0, 2)];
			repl = {$urandom, $urandom};
			case (ph)
				0: begin plen = 4'd8; rlen = 4'd8; end
				1: begin plen = 4'd1; rlen = 4'd1; end
				2: begin plen = 4'd0; rlen = 4'd0; end
				3: begin plen = 4'd15; rlen = 4'd9; end
				default: begin
					plen = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
						: 4'($urandom_range(1, 8));
					rlen = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
						: 4'($urandom_range(1, 8));
				end
			endcase
			if (ph == 4)
				cap = 16'd0;
			else if (ph == 5)
				cap = 16'hFFFF;
			else
				cap = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
			plen_eff = (plen == 0) ? 1 : ((plen > 8) ? 8 : int'(plen));

			settle();
			load_regs(pat, {60'd0, plen}, repl, {60'd0, rlen}, {48'd0, cap});
			sent = 0;
			while (sent < PHASE_BYTES) begin
				text_q.delete();
				target = $urandom_range(1, (ph % 3 == 0) ? 40 : 16);
				while (text_q.size() < target) begin
					case ($urandom_range(0, 9))
						0, 1, 2, 3: begin
							for (int k = 0; k < plen_eff; k++)
								text_q.push_back(pat[8*k +: 8]);
						end
						4: begin
							cut = $urandom_range(1, plen_eff);
							for (int k = 0; k < cut; k++)
								text_q.push_back(pat[8*k +: 8]);
						end
						5, 6: text_q.push_back(alpha[$urandom_range(0, 2)]);
						default: text_q.push_back(8'($urandom));
					endcase
				end
				send_text();
				sent += text_q.size();
				if ($urandom_range(0, 7) == 0)
					settle();
			end
		end

		settle();
		if (fail_count == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/sfr_pkg.sv
rtl/core/sfr_in_if.sv
rtl/core/sfr_out_if.sv
rtl/core/sfr_step.sv
rtl/core/sfr_burst_q.sv
rtl/core/stream_find_replace.sv
tb/sfr_edit_checker.sv
tb/tb_top.sv
